### rtl/wrr_pkg.sv
// Package: types and constants for the weighted round robin scheduler.
`timescale 1ns / 1ps
package wrr_pkg;
  localparam int MAX_FLOWS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [2:0] ST_ENQ    = 3'd0;
  localparam logic [2:0] ST_SENT   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_QFULL  = 3'd3;
  localparam logic [2:0] ST_FTFULL = 3'd4;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] flow_key;
    logic [31:0] packet_id;
    logic [15:0] packet_length;
    logic [47:0] arrival_time;
    logic        weight_present;
    logic [7:0]  flow_weight;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sent_packet_id;
    logic [47:0] start_time;
    logic [3:0]  flow_index;
    logic [47:0] clock_now;
  } out_item_t;
endpackage

### rtl/wrr_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module wrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/weighted_round_robin_scheduler.sv
// Top level: weighted round robin packet scheduler with memory-held state.
//
//  channel | ports                      | direction | payload
//  in      | in_valid, in_stall, in_item  | in        | in_item_t
//  out     | out_valid, out_stall, out_item| out       | out_item_t
//  cfg     | cfg_we, cfg_wdata           | in        | default weight
//
// One item at a time. Enqueue: a key scan over the known flow slots, states
// KRD and KCHK per slot (key/weight RAM, one read a cycle), then the fill/head
// read, the packet write and the result (ERD, EWR, OUT). Dequeue: up to
// MAX_FLOWS+1 slot visits, states DRD and DCHK (flow state and key/weight RAM
// read), then the packet read and the result (PRD, PDONE, OUT); a dequeue with
// nothing queued goes straight to the result. Reset is synchronous; the flow
// state RAM is cleared slot by slot after reset, during which no item is accepted.
// The result sits in an output register; the next item is accepted while it
// waits, and its own result is held back until that register frees.
`timescale 1ns / 1ps
module weighted_round_robin_scheduler #(
  parameter int MAX_FLOWS   = wrr_pkg::MAX_FLOWS_DEF,
  parameter int QUEUE_DEPTH = wrr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wrr_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output wrr_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import wrr_pkg::*;

  localparam int FW  = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int CW  = $clog2(MAX_FLOWS + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW  = FW + QW;
  localparam int SW  = QW + QCW;       // flow state: head, fill
  localparam int KW  = 64 + 8;         // key and weight

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_KRD   = 4'd2;
  localparam logic [3:0] S_KCHK  = 4'd3;
  localparam logic [3:0] S_ERD   = 4'd4;
  localparam logic [3:0] S_EWR   = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DCHK  = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PDONE = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]     state_r, state_nxt;
  in_item_t       item_r, item_nxt;
  out_item_t      res_r, res_nxt;
  out_item_t      pend_r, pend_nxt;   // result of the item in work
  logic           res_valid_r, res_valid_nxt;
  logic [7:0]     dw_r, dw_nxt;
  logic [CW-1:0]  fcount_r, fcount_nxt;
  logic [FW-1:0]  rp_r, rp_nxt;
  logic [7:0]     quota_r, quota_nxt;
  logic [47:0]    clk_r, clk_nxt;
  logic [CW-1:0]  nonempty_r, nonempty_nxt;  // flows with fill != 0
  logic [FW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  tries_r, tries_nxt;
  logic           found_r, found_nxt;
  logic [QW-1:0]  head_r, head_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;

  // key/weight RAM
  logic           k_we;
  logic [FW-1:0]  k_waddr, k_raddr;
  logic [KW-1:0]  k_wdata, k_rdata;
  // flow state RAM
  logic           s_we;
  logic [FW-1:0]  s_waddr, s_raddr;
  logic [SW-1:0]  s_wdata, s_rdata;
  // packet RAM
  logic           p_we;
  logic [PW-1:0]  p_waddr, p_raddr;
  logic [47:0]    p_wdata, p_rdata;

  wrr_ram #(.WIDTH(KW), .DEPTH(1 << FW)) u_keys (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata));
  wrr_ram #(.WIDTH(SW), .DEPTH(1 << FW)) u_fstate (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  wrr_ram #(.WIDTH(48), .DEPTH(1 << PW)) u_pkts (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata));

  logic           out_free;
  logic [QW-1:0]  s_head;
  logic [QCW-1:0] s_fill;
  logic [48:0]    clk_sum;
  logic [FW-1:0]  idx_inc, rp_inc;
  logic [QW:0]    tail_sum;
  logic [QW-1:0]  tail, head_inc;
  logic           ins_last;

  assign s_head   = s_rdata[SW-1 -: QW];
  assign s_fill   = s_rdata[QCW-1:0];
  assign out_free = !res_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = res_valid_r;
  assign out_item  = res_r;
  assign clk_sum   = {1'b0, clk_r} + {33'd0, p_rdata[47:32]};
  assign idx_inc   = idx_r + FW'(1);
  assign rp_inc    = ({1'b0, rp_r} + 1'b1 >= (FW+1)'(fcount_r)) ? '0 : rp_r + FW'(1);
  assign tail_sum  = {1'b0, head_r} + (QW+1)'(fill_r);
  assign tail      = (32'(tail_sum) >= QUEUE_DEPTH) ? QW'(32'(tail_sum) - QUEUE_DEPTH)
                                                    : tail_sum[QW-1:0];
  assign head_inc  = (32'(head_r) + 1 >= QUEUE_DEPTH) ? '0 : head_r + QW'(1);
  assign ins_last  = ((CW+1)'(idx_r) + 1'b1 >= (CW+1)'(fcount_r));

  always_comb begin
    state_nxt = state_r;   item_nxt = item_r;  res_nxt = res_r;  pend_nxt = pend_r;
    res_valid_nxt = res_valid_r && out_stall;
    dw_nxt = cfg_we ? cfg_wdata : dw_r;
    fcount_nxt = fcount_r; rp_nxt = rp_r; quota_nxt = quota_r; clk_nxt = clk_r;
    nonempty_nxt = nonempty_r; idx_nxt = idx_r; tries_nxt = tries_r;
    found_nxt = found_r; head_nxt = head_r; fill_nxt = fill_r;
    k_we = 1'b0; k_waddr = idx_r; k_wdata = {item_r.flow_key, dw_r}; k_raddr = idx_r;
    s_we = 1'b0; s_waddr = idx_r; s_wdata = {head_r, fill_r}; s_raddr = idx_r;
    p_we = 1'b0; p_waddr = {idx_r, tail};
    p_wdata = {item_r.packet_length, item_r.packet_id};
    p_raddr = {idx_r, head_r};
    case (state_r)
      S_CLEAR: begin
        s_we = 1'b1; s_wdata = '0;
        idx_nxt = idx_inc;
        if (32'(idx_r) == MAX_FLOWS - 1) begin
          idx_nxt = '0; state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_item; idx_nxt = '0; found_nxt = 1'b0; tries_nxt = '0;
          if (in_item.cmd == CMD_DEQ) begin
            if (fcount_r == '0 || nonempty_r == '0) begin
              pend_nxt = '{ST_EMPTY, 32'd0, 48'd0, 4'd0, clk_r};
              state_nxt = S_OUT;
            end else begin
              idx_nxt = rp_r; state_nxt = S_DRD;
            end
          end else if (fcount_r == '0) begin
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_KRD;
          end
        end
      end
      S_KRD: state_nxt = S_KCHK;  // key RAM read in flight
      S_KCHK: begin
        if (k_rdata[KW-1:8] == item_r.flow_key) begin
          found_nxt = 1'b1; state_nxt = S_ERD;
        end else if (ins_last) begin
          if (32'(fcount_r) >= MAX_FLOWS) begin
            pend_nxt = '{ST_FTFULL, 32'd0, 48'd0, 4'd0, clk_r};
            state_nxt = S_OUT;
          end else begin
            idx_nxt = FW'(fcount_r); state_nxt = S_ERD;
          end
        end else begin
          idx_nxt = idx_inc; state_nxt = S_KRD;
        end
      end
      S_ERD: begin
        head_nxt = found_r ? s_head : '0;
        fill_nxt = found_r ? s_fill : '0;
        state_nxt = S_EWR;
      end
      S_EWR: begin
        if (found_r && 32'(fill_r) >= QUEUE_DEPTH) begin
          pend_nxt = '{ST_QFULL, 32'd0, 48'd0, 4'(idx_r), clk_r};
        end else begin
          if (!found_r) begin
            k_we = 1'b1;
            k_wdata = {item_r.flow_key,
                       item_r.weight_present ? item_r.flow_weight : dw_r};
            fcount_nxt = fcount_r + CW'(1);
          end
          if (nonempty_r == '0) begin
            clk_nxt = item_r.arrival_time; rp_nxt = '0; quota_nxt = '0;
          end
          if (fill_r == '0) nonempty_nxt = nonempty_r + CW'(1);
          p_we = 1'b1;
          s_we = 1'b1; s_wdata = {head_r, fill_r + QCW'(1)};
          pend_nxt = '{ST_ENQ, 32'd0, 48'd0, 4'(idx_r),
                       (nonempty_r == '0) ? item_r.arrival_time : clk_r};
        end
        state_nxt = S_OUT;
      end
      S_DRD: begin
        s_raddr = rp_r; k_raddr = rp_r; state_nxt = S_DCHK;
      end
      S_DCHK: begin
        if (s_fill != '0 && quota_r < k_rdata[7:0]) begin
          idx_nxt = rp_r; head_nxt = s_head; fill_nxt = s_fill;
          state_nxt = S_PRD;
        end else if (32'(tries_r) >= 32'(fcount_r)) begin
          rp_nxt = rp_inc; quota_nxt = '0;
          pend_nxt = '{ST_EMPTY, 32'd0, 48'd0, 4'd0, clk_r};
          state_nxt = S_OUT;
        end else begin
          rp_nxt = rp_inc; quota_nxt = '0; tries_nxt = tries_r + CW'(1);
          state_nxt = S_DRD;
        end
      end
      S_PRD: begin
        s_we = 1'b1;
        s_wdata = {head_inc, fill_r - QCW'(1)};
        if (fill_r == QCW'(1)) nonempty_nxt = nonempty_r - CW'(1);
        quota_nxt = quota_r + 8'd1;
        state_nxt = S_PDONE;
      end
      S_PDONE: begin
        clk_nxt = clk_sum[48] ? TIME_MAX : clk_sum[47:0];
        pend_nxt = '{ST_SENT, p_rdata[31:0], clk_r, 4'(idx_r),
                     clk_sum[48] ? TIME_MAX : clk_sum[47:0]};
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          res_nxt = pend_r; res_valid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; res_valid_r <= 1'b0; dw_r <= 8'd1;
      fcount_r <= '0; rp_r <= '0; quota_r <= '0; clk_r <= '0;
      nonempty_r <= '0; idx_r <= '0; tries_r <= '0; found_r <= 1'b0;
    end else begin
      state_r <= state_nxt; res_valid_r <= res_valid_nxt; dw_r <= dw_nxt;
      fcount_r <= fcount_nxt; rp_r <= rp_nxt; quota_r <= quota_nxt; clk_r <= clk_nxt;
      nonempty_r <= nonempty_nxt; idx_r <= idx_nxt; tries_r <= tries_nxt;
      found_r <= found_nxt;
    end
    item_r <= item_nxt; res_r <= res_nxt; pend_r <= pend_nxt;
    head_r <= head_nxt; fill_r <= fill_nxt;
  end
endmodule
